### hw/rtl/odd_even_merge_unit_assert.svh
// assertion macros for the odd-even merge unit
`ifndef ODD_EVEN_MERGE_UNIT_ASSERT_SVH
`define ODD_EVEN_MERGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define OEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define OEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OEM_ASSERT_IMP(lbl, ante, cons, msg)
`define OEM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/oem_pkg.sv
// shared types and codes for the odd-even merge unit
`default_nettype none
package oem_pkg;

  typedef logic signed [31:0] data_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD_A = 2'd0;
  localparam kind_t KIND_LOAD_B = 2'd1;
  localparam kind_t KIND_MERGE  = 2'd2;

  // register index as decoded from paddr[2]
  localparam logic [0:0] REG_DESCENDING = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M_RD,
    ST_M_CMP,
    ST_E_RD,
    ST_E_CMP,
    ST_E_SECOND
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/odd_even_merge_unit.sv
// top level of the odd-even merge unit: list stores, run stores, sequencer
//
// Batcher odd-even merge of two presorted lists of signed 32-bit values.
// A load transfer (kind A or B) appends its value to that list;
// a load into a full list is dropped and sets a sticky flag that is reported
// on every result of the next merge. A merge transfer first merges the even-
// indexed elements of both lists into an even run, then the odd-indexed ones
// into an odd run, and then emits even[0], compare-exchanged pairs
// (even[i+1], odd[i]) and the leftovers, flagging the final result with last.
// Both lists and the drop flag clear when the merge finishes; a merge of two
// empty lists gives no result. Register 0 (bit 0) picks descending order.
// A merge is sequenced over one comparator and stores with registered
// reads: each run element is read, then compared and written, and each
// run closes with one more read and compare; emitting reads even[0] and
// each leftover and then pushes it, reads each exchanged pair and pushes
// its first and then its second element, and finishes with a last read
// and compare. in_ready is low for the whole merge, and a push waits while
// the output is stalled. The result register lets the last result wait for
// its transfer while new loads are already taken.
`default_nettype none
`include "odd_even_merge_unit_assert.svh"
module odd_even_merge_unit #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  oem_pkg::kind_t       in_kind,
  input  logic signed [31:0]   in_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_value_res,
  output logic                 out_last,
  output logic                 out_dropped,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import oem_pkg::*;

  // list index and count widths; list counters run up to count + 1
  localparam int LIDX_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LCNT_W    = $clog2(LIST_DEPTH + 2);
  // the even run holds up to LIST_DEPTH + 1 elements
  localparam int RUN_DEPTH = LIST_DEPTH + 1;
  localparam int RIDX_W    = $clog2(RUN_DEPTH);
  localparam int RCNT_W    = $clog2(RUN_DEPTH + 1);

  // configuration
  logic desc_r;

  // control state
  state_t             state_r, state_nxt;
  logic [LCNT_W-1:0]  count_a_r, count_a_nxt;
  logic [LCNT_W-1:0]  count_b_r, count_b_nxt;
  logic               ovf_r, ovf_nxt;
  logic               par_r, par_nxt;       // 0 even run, 1 odd run
  logic [LCNT_W-1:0]  i_r, i_nxt;           // walk position in list a
  logic [LCNT_W-1:0]  j_r, j_nxt;           // walk position in list b
  logic [RCNT_W-1:0]  n_r, n_nxt;           // run write position
  logic [RCNT_W-1:0]  ne_r, ne_nxt;         // even run length
  logic [RCNT_W-1:0]  no_r, no_nxt;         // odd run length
  logic [RCNT_W-1:0]  ei_r, ei_nxt;         // emit position in even run
  logic [RCNT_W-1:0]  oj_r, oj_nxt;         // emit position in odd run
  logic               first_r, first_nxt;   // even[0] not yet emitted

  // held second element of an exchanged pair
  data_t              sec_r, sec_nxt;
  logic               sec_last_r, sec_last_nxt;

  // stores with registered reads
  data_t list_a_mem [LIST_DEPTH];
  data_t list_b_mem [LIST_DEPTH];
  data_t even_mem   [RUN_DEPTH];
  data_t odd_mem    [RUN_DEPTH];
  data_t a_q, b_q, e_q, o_q;

  logic  list_a_we, list_b_we, run_we, even_we, odd_we;
  data_t run_wdata;

  // result register
  logic  out_valid_r;
  data_t out_value_r;
  logic  out_last_r, out_dropped_r;
  logic  out_free, push, push_last;
  data_t push_val;

  // shared comparator
  data_t cmp_a, cmp_b;
  logic  a_first;

  logic a_ok, b_ok, take_a, e_ok, o_ok, pair;

  // ---------------------------------------------------------------------
  // configuration port: always ready, write on the access cycle
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_DESCENDING) ? {31'b0, desc_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2:2] == REG_DESCENDING)) begin
      desc_r <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------
  // the one comparator: list heads while merging runs, run heads on emit
  // ---------------------------------------------------------------------
  assign cmp_a = (state_r == ST_M_CMP) ? a_q : e_q;
  assign cmp_b = (state_r == ST_M_CMP) ? b_q : o_q;

  oem_cmp u_cmp (
    .op_a       (cmp_a),
    .op_b       (cmp_b),
    .descending (desc_r),
    .a_first    (a_first)
  );

  // ---------------------------------------------------------------------
  // stores: one write and one registered read each per cycle
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (list_a_we) begin
      list_a_mem[count_a_r[LIDX_W-1:0]] <= in_value;
    end
    a_q <= list_a_mem[i_r[LIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (list_b_we) begin
      list_b_mem[count_b_r[LIDX_W-1:0]] <= in_value;
    end
    b_q <= list_b_mem[j_r[LIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[n_r[RIDX_W-1:0]] <= run_wdata;
    end
    e_q <= even_mem[ei_r[RIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      odd_mem[n_r[RIDX_W-1:0]] <= run_wdata;
    end
    o_q <= odd_mem[oj_r[RIDX_W-1:0]];
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // run merge: which list still has elements of the current parity
  assign a_ok   = (i_r < count_a_r);
  assign b_ok   = (j_r < count_b_r);
  assign take_a = a_ok && (!b_ok || a_first);

  // emit: what is left of each run
  assign e_ok = (ei_r < ne_r);
  assign o_ok = (oj_r < no_r);
  assign pair = !first_r && e_ok && o_ok;

  assign even_we   = run_we && !par_r;
  assign odd_we    = run_we && par_r;
  assign run_wdata = take_a ? a_q : b_q;

  always_comb begin
    state_nxt    = state_r;
    count_a_nxt  = count_a_r;
    count_b_nxt  = count_b_r;
    ovf_nxt      = ovf_r;
    par_nxt      = par_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    n_nxt        = n_r;
    ne_nxt       = ne_r;
    no_nxt       = no_r;
    ei_nxt       = ei_r;
    oj_nxt       = oj_r;
    first_nxt    = first_r;
    sec_nxt      = sec_r;
    sec_last_nxt = sec_last_r;
    list_a_we    = 1'b0;
    list_b_we    = 1'b0;
    run_we       = 1'b0;
    push         = 1'b0;
    push_val     = e_q;
    push_last    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_LOAD_A: begin
              if (count_a_r < LCNT_W'(LIST_DEPTH)) begin
                list_a_we   = 1'b1;
                count_a_nxt = count_a_r + LCNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_LOAD_B: begin
              if (count_b_r < LCNT_W'(LIST_DEPTH)) begin
                list_b_we   = 1'b1;
                count_b_nxt = count_b_r + LCNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_MERGE: begin
              par_nxt   = 1'b0;
              i_nxt     = '0;
              j_nxt     = '0;
              n_nxt     = '0;
              state_nxt = ST_M_RD;
            end
            default: ;
          endcase
        end
      end

      ST_M_RD: begin
        state_nxt = ST_M_CMP;
      end

      ST_M_CMP: begin
        if (!a_ok && !b_ok) begin
          if (!par_r) begin
            // even run closed, start the odd one
            ne_nxt    = n_r;
            par_nxt   = 1'b1;
            i_nxt     = LCNT_W'(1);
            j_nxt     = LCNT_W'(1);
            n_nxt     = '0;
            state_nxt = ST_M_RD;
          end else begin
            no_nxt    = n_r;
            ei_nxt    = '0;
            oj_nxt    = '0;
            first_nxt = 1'b1;
            state_nxt = ST_E_RD;
          end
        end else begin
          run_we = 1'b1;
          n_nxt  = n_r + RCNT_W'(1);
          if (take_a) begin
            i_nxt = i_r + LCNT_W'(2);
          end else begin
            j_nxt = j_r + LCNT_W'(2);
          end
          state_nxt = ST_M_RD;
        end
      end

      ST_E_RD: begin
        state_nxt = ST_E_CMP;
      end

      ST_E_CMP: begin
        if (pair) begin
          if (out_free) begin
            push         = 1'b1;
            push_val     = a_first ? e_q : o_q;
            push_last    = 1'b0;
            sec_nxt      = a_first ? o_q : e_q;
            sec_last_nxt = ((ei_r + RCNT_W'(1)) >= ne_r) &&
                           ((oj_r + RCNT_W'(1)) >= no_r);
            ei_nxt       = ei_r + RCNT_W'(1);
            oj_nxt       = oj_r + RCNT_W'(1);
            state_nxt    = ST_E_SECOND;
          end
        end else if (e_ok) begin
          // even[0] or an even leftover
          if (out_free) begin
            push      = 1'b1;
            push_val  = e_q;
            push_last = ((ei_r + RCNT_W'(1)) >= ne_r) && !o_ok;
            ei_nxt    = ei_r + RCNT_W'(1);
            first_nxt = 1'b0;
            state_nxt = ST_E_RD;
          end
        end else if (o_ok) begin
          if (out_free) begin
            push      = 1'b1;
            push_val  = o_q;
            push_last = ((oj_r + RCNT_W'(1)) >= no_r);
            oj_nxt    = oj_r + RCNT_W'(1);
            first_nxt = 1'b0;
            state_nxt = ST_E_RD;
          end
        end else begin
          // everything emitted: lists and drop flag clear
          count_a_nxt = '0;
          count_b_nxt = '0;
          ovf_nxt     = 1'b0;
          first_nxt   = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      ST_E_SECOND: begin
        if (out_free) begin
          push      = 1'b1;
          push_val  = sec_r;
          push_last = sec_last_r;
          state_nxt = ST_E_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_a_r <= '0;
      count_b_r <= '0;
      ovf_r     <= 1'b0;
      par_r     <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      n_r       <= '0;
      ne_r      <= '0;
      no_r      <= '0;
      ei_r      <= '0;
      oj_r      <= '0;
      first_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      ovf_r     <= ovf_nxt;
      par_r     <= par_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      n_r       <= n_nxt;
      ne_r      <= ne_nxt;
      no_r      <= no_nxt;
      ei_r      <= ei_nxt;
      oj_r      <= oj_nxt;
      first_r   <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r      <= sec_nxt;
    sec_last_r <= sec_last_nxt;
  end

  // ---------------------------------------------------------------------
  // result register: holds one result until its transfer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_value_r   <= push_val;
      out_last_r    <= push_last;
      out_dropped_r <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last      = out_last_r;
  assign out_dropped   = out_dropped_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `OEM_ASSERT_IMP(a_count_bound, 1'b1, (count_a_r <= LCNT_W'(LIST_DEPTH)) && (count_b_r <= LCNT_W'(LIST_DEPTH)), "list count past depth")
  `OEM_ASSERT_IMP(a_emit_bound, (state_r == ST_E_CMP), (ei_r <= ne_r) && (oj_r <= no_r), "emit position past run end")
  `OEM_ASSERT_IMP(a_run_lengths, (state_r == ST_E_RD), (no_r <= ne_r), "odd run longer than even run")
  `OEM_ASSERT_NXT(a_merge_clears, (state_r == ST_E_CMP) && !e_ok && !o_ok, (state_r == ST_IDLE) && (count_a_r == '0) && (count_b_r == '0) && !ovf_r, "lists not cleared after merge")

endmodule
`default_nettype wire

### hw/rtl/oem_cmp.sv
// shared order comparator of the odd-even merge unit
`default_nettype none
module oem_cmp (
  input  oem_pkg::data_t op_a,
  input  oem_pkg::data_t op_b,
  input  logic           descending,
  output logic           a_first
);
  import oem_pkg::*;

  // strict: equal operands never put op_a first
  assign a_first = descending ? (op_a > op_b) : (op_a < op_b);

endmodule
`default_nettype wire

### tb/tb_odd_even_merge_unit.sv
// self-checking testbench for the odd-even merge unit: directed table, then random phases
`default_nettype none
module tb_odd_even_merge_unit;
  import oem_pkg::*;

  localparam int LIST_DEPTH = 32;
  // kind code the block must ignore without touching its lists
  localparam kind_t KIND_IGNORED = 2'd3;
  // byte address of the order register
  localparam logic [2:0] ORDER_ADDR = {REG_DESCENDING, 2'b00};
  // idle time after every owed result of a phase has come out
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS_PER_PHASE = 12;

  typedef struct {
    data_t value;
    logic  last;
    logic  dropped;
  } merged_t;

  // one row of the directed table; the value steps by step on each repeat
  typedef struct {
    kind_t kind;
    data_t value;
    int    reps;
    int    step;
    bit    typed;
    data_t exp_value;
    logic  exp_dropped;
  } row_t;

  localparam int NUM_ROWS = 21;

  logic clk;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  kind_t         in_kind = KIND_LOAD_A;
  data_t         in_value = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  data_t         out_value_res;
  logic          out_last;
  logic          out_dropped;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  odd_even_merge_unit #(.LIST_DEPTH(LIST_DEPTH)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_res(out_value_res),
    .out_last     (out_last),
    .out_dropped  (out_dropped),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // shadow copy of the block's lists, counts, drop flag and order register
  data_t list_a [LIST_DEPTH];
  data_t list_b [LIST_DEPTH];
  int    cnt_a = 0;
  int    cnt_b = 0;
  bit    overflow_flag = 1'b0;
  bit    desc_order = 1'b0;

  merged_t merge_out_q[$];   // merged elements still owed by the block
  merged_t fresh_q[$];       // elements produced by the item just taken
  int      errors = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  int      idle_pct = 16;    // sender gap chance per cycle, in percent
  int      stall_pct = 16;   // receiver stall chance per cycle, in percent

  // the directed table: extremes, ignored kind, empty merges, ties, overflow
  row_t stim_table [NUM_ROWS] = '{
    // merge right after reset: both lists empty, nothing comes out
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_LOAD_A,  32'sh7fffffff,   1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b1, 32'sh7fffffff,   1'b0},
    '{KIND_LOAD_B,  32'sh80000000,   1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b1, 32'sh80000000,   1'b0},
    // ignored kind with all value bits set and clear, then an empty merge
    '{KIND_IGNORED, -32'sd1,         1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_IGNORED, 32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   -32'sd1,         1, 0, 1'b0, 32'sd0,          1'b0},
    // small mixed-sign merge with uneven list lengths
    '{KIND_LOAD_A,  -32'sd5,         1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_LOAD_A,  32'sd3,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_LOAD_B,  -32'sd7,         1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_LOAD_B,  32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_LOAD_B,  32'sd9,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    // equal elements in both lists
    '{KIND_LOAD_A,  32'sd4,          2, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_LOAD_B,  32'sd4,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    // only list B, overfilled
    '{KIND_LOAD_B,  32'sd7,         33, 1, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    // the drop flag must have cleared with the previous merge
    '{KIND_LOAD_A,  32'sd0,          1, 0, 1'b0, 32'sd0,          1'b0},
    '{KIND_MERGE,   32'sd0,          1, 0, 1'b1, 32'sd0,          1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // strict ordering test for the selected direction
  function automatic bit comes_first(data_t x, data_t y);
    return desc_order ? (x > y) : (x < y);
  endfunction

  // update the shadow lists for one item; merged elements go to fresh_q
  function automatic void predict_merge(kind_t kind, data_t value);
    data_t part[$];
    data_t even_run[$];
    data_t odd_run[$];
    data_t seq[$];
    merged_t res;
    int i;
    int j;
    if (kind == KIND_LOAD_A || kind == KIND_LOAD_B) begin
      if (kind == KIND_LOAD_A) begin
        if (cnt_a < LIST_DEPTH) begin
          list_a[cnt_a] = value;
          cnt_a++;
        end else begin
          overflow_flag = 1'b1;
        end
      end else begin
        if (cnt_b < LIST_DEPTH) begin
          list_b[cnt_b] = value;
          cnt_b++;
        end else begin
          overflow_flag = 1'b1;
        end
      end
      return;
    end
    if (kind != KIND_MERGE) return;

    // even-indexed elements first, then odd-indexed; ties take list B
    for (int p = 0; p < 2; p++) begin
      part.delete();
      i = p;
      j = p;
      while (i < cnt_a && j < cnt_b) begin
        if (comes_first(list_a[i], list_b[j])) begin
          part.insert(part.size(), list_a[i]);
          i += 2;
        end else begin
          part.insert(part.size(), list_b[j]);
          j += 2;
        end
      end
      for (; i < cnt_a; i += 2) part.insert(part.size(), list_a[i]);
      for (; j < cnt_b; j += 2) part.insert(part.size(), list_b[j]);
      if (p == 0) even_run = part;
      else odd_run = part;
    end

    // first even element, exchanged pairs, then leftovers of each run
    if (even_run.size() > 0) seq.insert(seq.size(), even_run[0]);
    i = 1;
    j = 0;
    while (i < even_run.size() && j < odd_run.size()) begin
      if (comes_first(even_run[i], odd_run[j])) begin
        seq.insert(seq.size(), even_run[i]);
        seq.insert(seq.size(), odd_run[j]);
      end else begin
        seq.insert(seq.size(), odd_run[j]);
        seq.insert(seq.size(), even_run[i]);
      end
      i++;
      j++;
    end
    for (; i < even_run.size(); i++) seq.insert(seq.size(), even_run[i]);
    for (; j < odd_run.size(); j++) seq.insert(seq.size(), odd_run[j]);

    foreach (seq[k]) begin
      res.value = seq[k];
      res.last = (k == seq.size() - 1);
      res.dropped = overflow_flag;
      fresh_q.insert(fresh_q.size(), res);
    end
    cnt_a = 0;
    cnt_b = 0;
    overflow_flag = 1'b0;
  endfunction

  // one input transfer; a random gap may come first. a typed row replaces the
  // predicted elements with its single hand-written result
  task automatic send_item(kind_t kind, data_t value, bit typed, data_t exp_value,
                           logic exp_dropped);
    merged_t res;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    fresh_q.delete();
    predict_merge(kind, value);
    if (typed) begin
      res.value = exp_value;
      res.last = 1'b1;
      res.dropped = exp_dropped;
      merge_out_q.insert(merge_out_q.size(), res);
    end else begin
      foreach (fresh_q[k]) merge_out_q.insert(merge_out_q.size(), fresh_q[k]);
    end
    if (kind != KIND_IGNORED) items_sent++;
  endtask

  // stop sending and wait for every owed result, then let the block settle
  task automatic drain(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (merge_out_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_order(bit desc);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ORDER_ADDR;
    pwdata <= {31'd0, desc};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    desc_order = desc;
  endtask

  // random load sequences, mostly sorted in the current order, most closed by
  // a merge; some are unsorted, some are left unmerged, kind 3 is sprinkled in
  task automatic random_phase(int budget);
    data_t  vals [2][40];
    int     cnt [2];
    int     ia;
    int     ib;
    int     mode;
    int     pick;
    bit     sorted;
    longint cur;
    longint stride;
    int     start_items;
    start_items = items_sent;
    while (items_sent - start_items < budget) begin
      sorted = ($urandom_range(0, 9) != 0);
      for (int l = 0; l < 2; l++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) cnt[l] = $urandom_range(9, 12);
        else if (pick < 3) cnt[l] = 0;
        else cnt[l] = $urandom_range(1, 6);
        cur = longint'(int'($urandom));
        mode = $urandom_range(0, 3);
        for (int m = 0; m < cnt[l]; m++) begin
          if (!sorted) begin
            vals[l][m] = data_t'($urandom);
          end else begin
            vals[l][m] = data_t'(cur);
            case (mode)
              0: stride = $urandom_range(0, 1);
              1: stride = $urandom_range(0, 100);
              2: stride = $urandom_range(0, 1 << 20);
              default: stride = $urandom_range(0, 32'h7fffffff);
            endcase
            cur = desc_order ? cur - stride : cur + stride;
            // pin at the extremes of the signed range
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            if (cur < -64'sd2147483648) cur = -64'sd2147483648;
          end
        end
      end
      ia = 0;
      ib = 0;
      while (ia < cnt[0] || ib < cnt[1]) begin
        if (ib >= cnt[1] || (ia < cnt[0] && $urandom_range(0, 1) == 1)) begin
          send_item(KIND_LOAD_A, vals[0][ia], 1'b0, '0, 1'b0);
          ia++;
        end else begin
          send_item(KIND_LOAD_B, vals[1][ib], 1'b0, '0, 1'b0);
          ib++;
        end
        if ($urandom_range(0, 15) == 0)
          send_item(KIND_IGNORED, data_t'($urandom), 1'b0, '0, 1'b0);
      end
      // now and then leave the lists for the next sequence to extend
      if ($urandom_range(0, 9) != 0) begin
        send_item(KIND_MERGE, data_t'($urandom), 1'b0, '0, 1'b0);
        // hold off the sender until every owed result has come out
        if ($urandom_range(0, 4) == 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (merge_out_q.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  // receiver: random stalls at the rate set for the phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker: compare each transfer with the oldest owed element
  always @(posedge clk) begin
    merged_t want;
    if (rst_n && out_valid && out_ready) begin
      if (merge_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d last %0b dropped %0b",
                 $time, out_value_res, out_last, out_dropped);
        errors++;
      end else begin
        want = merge_out_q.pop_front();
        if (out_value_res !== want.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, want.value, out_value_res);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_last);
          errors++;
        end
        if (out_dropped !== want.dropped) begin
          $display("%0t: dropped mismatch, expected %0b, got %0b",
                   $time, want.dropped, out_dropped);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (list_a[k]) begin
      list_a[k] = '0;
      list_b[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table in ascending order, the reset setting
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int n = 0; n < stim_table[r].reps; n++) begin
        send_item(stim_table[r].kind, data_t'(stim_table[r].value + n * stim_table[r].step),
                  stim_table[r].typed, stim_table[r].exp_value, stim_table[r].exp_dropped);
      end
    end

    // descending, with random gaps and stalls
    drain(SETTLE_CYCLES);
    write_order(1'b1);
    random_phase(RANDOM_ITEMS_PER_PHASE);

    // ascending, with no gaps and no stalls at all
    drain(SETTLE_CYCLES);
    write_order(1'b0);
    idle_pct = 0;
    stall_pct = 0;
    random_phase(RANDOM_ITEMS_PER_PHASE);

    // descending again, gaps and stalls back on
    drain(SETTLE_CYCLES);
    write_order(1'b1);
    idle_pct = 16;
    stall_pct = 16;
    random_phase(RANDOM_ITEMS_PER_PHASE);

    drain(SETTLE_CYCLES);
    if (errors == 0 && merge_out_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
